// ----- hw/rtl/dtom_pkg.sv -----
package dtom_pkg;

	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned FRAC_W     = 52;
	localparam int unsigned EFIELD_W   = 11;
	localparam int unsigned SIG_W      = FRAC_W + 1;
	localparam int unsigned MANT_W     = 54;
	localparam int unsigned EXP_W      = 12;
	localparam int unsigned MWIDTH_W   = 6;
	localparam int unsigned EWIDTH_W   = 4;
	localparam int unsigned SHIFT_W    = 6;
	localparam int unsigned EXP_BIAS   = 1075;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [SIG_W-1:0]   sig_t;

	typedef struct packed {
		logic signed [MANT_W-1:0] odd_mantissa;
		logic signed [EXP_W-1:0]  scale_exponent;
		logic [MWIDTH_W-1:0]      mantissa_width;
		logic [EWIDTH_W-1:0]      exponent_width;
	} result_t;

	// count of zero bits below the lowest set bit; 0 for a zero input
	function automatic logic [SHIFT_W-1:0] trail_zeros(input sig_t s);
		logic [SHIFT_W-1:0] n;
		n = '0;
		for (int i = SIG_W - 1; i >= 0; i--) begin
			if (s[i]) begin
				n = SHIFT_W'(i);
			end
		end
		return n;
	endfunction

	// position of the highest set bit plus one; 0 for a zero input
	function automatic logic [SHIFT_W-1:0] bit_len(input sig_t s);
		logic [SHIFT_W-1:0] n;
		n = '0;
		for (int i = 0; i < SIG_W; i++) begin
			if (s[i]) begin
				n = SHIFT_W'(i + 1);
			end
		end
		return n;
	endfunction

	// minimal two's complement width of a signed exponent, sign included
	function automatic logic [EWIDTH_W-1:0] exp_width(input logic [EXP_W-1:0] e);
		logic [EXP_W-1:0]    m;
		logic [EWIDTH_W-1:0] n;
		m = e[EXP_W-1] ? ~e : e;
		n = '0;
		for (int i = 0; i < EXP_W; i++) begin
			if (m[i]) begin
				n = EWIDTH_W'(i + 1);
			end
		end
		return (e == '0) ? '0 : n + EWIDTH_W'(1);
	endfunction

endpackage

// ----- hw/rtl/dtom_in_if.sv -----
interface dtom_in_if;
	logic                  valid;
	logic                  ready;
	dtom_pkg::value_t      value_bits;

	modport source (output valid, output value_bits, input ready);
	modport sink   (input valid, input value_bits, output ready);
endinterface

// ----- hw/rtl/dtom_out_if.sv -----
interface dtom_out_if;
	logic                                        valid;
	logic                                        ready;
	logic signed [dtom_pkg::MANT_W-1:0]          odd_mantissa;
	logic signed [dtom_pkg::EXP_W-1:0]           scale_exponent;
	logic [dtom_pkg::MWIDTH_W-1:0]               mantissa_width;
	logic [dtom_pkg::EWIDTH_W-1:0]               exponent_width;

	modport source (output valid, output odd_mantissa, output scale_exponent,
		output mantissa_width, output exponent_width, input ready);
	modport sink   (input valid, input odd_mantissa, input scale_exponent,
		input mantissa_width, input exponent_width, output ready);
endinterface

// ----- hw/rtl/dtom_decomp.sv -----
module dtom_decomp (
	input  dtom_pkg::value_t  value_bits,
	output dtom_pkg::result_t result
);
	import dtom_pkg::*;

	logic                  neg;
	logic [EFIELD_W-1:0]   efield;
	sig_t                  sig;
	logic                  sig_zero;
	logic [SHIFT_W-1:0]    tz;
	logic [SHIFT_W-1:0]    len;
	sig_t                  odd;
	logic                  odd_one;
	logic [EXP_W-1:0]      exp_base;
	logic [EXP_W-1:0]      expo;
	logic [MANT_W-1:0]     mag;

	// field split, hidden bit and zero-exponent handling
	assign neg      = value_bits[VALUE_W-1];
	assign efield   = value_bits[VALUE_W-2 -: EFIELD_W];
	assign sig      = {efield != '0, value_bits[FRAC_W-1:0]};
	assign sig_zero = (sig == '0);

	// strip trailing zeros
	assign tz      = trail_zeros(sig);
	assign len     = bit_len(sig) - tz;
	assign odd     = sig >> tz;
	assign odd_one = (odd == sig_t'(1));

	// unbias and raise by the stripped count
	assign exp_base = ((efield == '0) ? EXP_W'(1) : EXP_W'(efield))
		- EXP_W'(EXP_BIAS);
	assign expo     = exp_base + EXP_W'(tz);

	// sign and widths
	assign mag = {{(MANT_W-SIG_W){1'b0}}, odd};

	always_comb begin
		if (sig_zero) begin
			result = '0;
		end else begin
			result.odd_mantissa   = neg ? -mag : mag;
			result.scale_exponent = expo;
			result.mantissa_width = len + ((neg && odd_one) ? MWIDTH_W'(0) : MWIDTH_W'(1));
			result.exponent_width = exp_width(expo);
		end
	end
endmodule

// ----- hw/rtl/double_to_odd_mantissa_exponent_top.sv -----
// channel  dir  payload
// in_ch    in   value_bits (64)
// out_ch   out  odd_mantissa (54 s), scale_exponent (12 s),
//               mantissa_width (6), exponent_width (4)
//
// one request per cycle sustained while out_ch.ready stays high; input register to
// result register with the decomposition logic between them
// arst_n clears both stage valid flags; payload registers are not reset
// a stalled result holds in the result register while an empty input register
// still takes a request; in_ch.ready drops only when both stages are full
module double_to_odd_mantissa_exponent_top (
	input logic         clk,
	input logic         arst_n,
	dtom_in_if.sink     in_ch,
	dtom_out_if.source  out_ch
);
	import dtom_pkg::*;

	logic    v_s1;
	value_t  value_s1;
	logic    v_s2;
	result_t res_s2;
	result_t res_comb;
	logic    adv_s2;
	logic    adv_s1;

	// stage handshake
	assign adv_s2      = !v_s2 || out_ch.ready;
	assign adv_s1      = !v_s1 || adv_s2;
	assign in_ch.ready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_ch.valid) begin
			value_s1 <= in_ch.value_bits;
		end
	end

	dtom_decomp u_decomp (
		.value_bits (value_s1),
		.result     (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			res_s2 <= res_comb;
		end
	end

	// output drive
	assign out_ch.valid          = v_s2;
	assign out_ch.odd_mantissa   = res_s2.odd_mantissa;
	assign out_ch.scale_exponent = res_s2.scale_exponent;
	assign out_ch.mantissa_width = res_s2.mantissa_width;
	assign out_ch.exponent_width = res_s2.exponent_width;
endmodule
